>>> hdl/tla_pkg.sv
// shared constants and types for the telnet line assembler
// no dependencies; used by telnet_line_assembler

package tla_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = 6;
    localparam int LEN_W       = 7;
    localparam int LINE_CAP    = 64;

    localparam logic [7:0] BYTE_BS    = 8'd8;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_SPACE = 8'd32;
    localparam logic [7:0] BYTE_TILDE = 8'd126;
    localparam logic [7:0] BYTE_DEL   = 8'd127;
    localparam logic [7:0] BYTE_IAC_E = 8'd224;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } t_state;

endpackage

>>> hdl/telnet_line_assembler.sv
// telnet line assembler: cooked-mode line buffer in a 64-entry line memory
// depends on tla_pkg
//
// usage:
//   s_axis carries received bytes: tdata is the byte, tuser marks the first byte
//   of a receive chunk. m_axis returns the lines: tdata[6:0] is one character,
//   tuser[0] says a character is present (0 for an empty line), tuser[1] says
//   characters were dropped on a full buffer, tlast marks the end of a line.
//   an ordinary byte changes the buffer as soon as it is taken.
//   CR or LF starts a replay of the stored line from the memory: each result
//   takes a memory read (S_READ) and then a load of the output register
//   (S_LOAD), and no input is taken until the whole line has been replayed
//   (a single empty item for an empty line).
//   the output register decouples the sides: while a result waits on a stalled
//   receiver, plain bytes are still taken; only the replay itself pauses.
//   reset clears the length, the flags and the output valid; the line memory
//   needs no clearing since only written entries are ever used.

module telnet_line_assembler #(
    parameter int LINE_CAP = tla_pkg::LINE_CAP
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tuser,   // [0] chunk_start
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] line_char, [7] zero fill
    output logic [1:0] m_axis_tuser,   // [0] char_present, [1] truncated
    output logic       m_axis_tlast    // last_of_line
);

    localparam int LEN_W = tla_pkg::LEN_W;
    localparam int IDX_W = tla_pkg::IDX_W;
    // usable capacity held to 1..STORE_DEPTH
    localparam int CAP_USED = (LINE_CAP < 1) ? 1 :
        ((LINE_CAP > tla_pkg::STORE_DEPTH) ? tla_pkg::STORE_DEPTH : LINE_CAP);
    localparam logic [LEN_W-1:0] CAP = LEN_W'(CAP_USED);

    tla_pkg::t_state r_state, n_state;

    logic [LEN_W-1:0] r_len, n_len;
    logic             r_drop, n_drop;
    logic             r_after_nl, n_after_nl;
    logic             r_ovf, n_ovf;

    logic [LEN_W-1:0] r_emit_len, n_emit_len;
    logic             r_emit_tr, n_emit_tr;
    logic [IDX_W-1:0] r_idx, n_idx;

    logic [6:0] r_mem [tla_pkg::STORE_DEPTH];
    logic [6:0] r_rd_data;
    logic       w_we;

    logic       r_out_valid, n_out_valid;
    logic [6:0] r_out_char, n_out_char;
    logic       r_out_present, n_out_present;
    logic       r_out_last, n_out_last;
    logic       r_out_tr, n_out_tr;

    logic       w_in_xfer;
    logic [7:0] w_b;
    logic       w_printable;
    logic       w_newline;
    logic       w_load_last;

    assign w_in_xfer   = s_axis_tvalid && s_axis_tready;
    assign w_b         = s_axis_tdata;
    assign w_printable = (w_b >= tla_pkg::BYTE_SPACE) && (w_b <= tla_pkg::BYTE_TILDE);
    assign w_newline   = (w_b == tla_pkg::BYTE_CR) || (w_b == tla_pkg::BYTE_LF);
    assign w_load_last = (r_emit_len == '0) || ((LEN_W'(r_idx) + LEN_W'(1)) == r_emit_len);

    assign s_axis_tready = (r_state == tla_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_char};
    assign m_axis_tuser  = {r_out_tr, r_out_present};
    assign m_axis_tlast  = r_out_last;

    always_comb begin
        logic act;
        act           = 1'b0;
        n_state       = r_state;
        n_len         = r_len;
        n_drop        = r_drop;
        n_after_nl    = r_after_nl;
        n_ovf         = r_ovf;
        n_emit_len    = r_emit_len;
        n_emit_tr     = r_emit_tr;
        n_idx         = r_idx;
        w_we          = 1'b0;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_char    = r_out_char;
        n_out_present = r_out_present;
        n_out_last    = r_out_last;
        n_out_tr      = r_out_tr;

        unique case (r_state)
            tla_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    // decide whether the byte reaches the line logic at all
                    if (s_axis_tuser) begin
                        n_drop     = 1'b0;
                        n_after_nl = 1'b0;
                        if (!w_printable && !w_newline) begin
                            n_drop = 1'b1;
                        end else begin
                            act = 1'b1;
                        end
                    end else if (r_drop) begin
                        act = 1'b0;
                    end else if (r_after_nl) begin
                        // swallow the LF of a CR LF pair and similar
                        n_after_nl = 1'b0;
                        act        = (w_b >= tla_pkg::BYTE_SPACE) && !w_b[7];
                    end else begin
                        act = 1'b1;
                    end

                    if (act) begin
                        priority if (w_b == tla_pkg::BYTE_DEL || w_b == tla_pkg::BYTE_IAC_E) begin
                            n_len = r_len;
                        end else if (w_b == tla_pkg::BYTE_BS) begin
                            if (r_len != '0) begin
                                n_len = r_len - LEN_W'(1);
                            end
                        end else if (w_newline) begin
                            n_after_nl = 1'b1;
                            n_emit_len = r_len;
                            n_emit_tr  = r_ovf;
                            n_idx      = '0;
                            n_len      = '0;
                            n_ovf      = 1'b0;
                            n_state    = tla_pkg::S_READ;
                        end else if (w_printable) begin
                            if (r_len < CAP) begin
                                w_we  = 1'b1;
                                n_len = r_len + LEN_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end else begin
                            n_len = r_len;
                        end
                    end
                end
            end
            tla_pkg::S_READ: begin
                // memory read of entry r_idx is in flight
                n_state = tla_pkg::S_LOAD;
            end
            tla_pkg::S_LOAD: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid   = 1'b1;
                    n_out_char    = (r_emit_len == '0) ? 7'd0 : r_rd_data;
                    n_out_present = (r_emit_len != '0);
                    n_out_last    = w_load_last;
                    n_out_tr      = r_emit_tr;
                    if (w_load_last) begin
                        n_state = tla_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = tla_pkg::S_READ;
                    end
                end
            end
            default: begin
                n_state = tla_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_len[IDX_W-1:0]] <= w_b[6:0];
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tla_pkg::S_IDLE;
            r_len       <= '0;
            r_drop      <= 1'b0;
            r_after_nl  <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_drop      <= n_drop;
            r_after_nl  <= n_after_nl;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_emit_len    <= n_emit_len;
        r_emit_tr     <= n_emit_tr;
        r_idx         <= n_idx;
        r_out_char    <= n_out_char;
        r_out_present <= n_out_present;
        r_out_last    <= n_out_last;
        r_out_tr      <= n_out_tr;
    end

    a_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CAP)
        else $error("line length beyond capacity");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 8'd0))
        else $error("empty line result not a single zero item");

    a_cleared_during_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != tla_pkg::S_IDLE |-> (r_len == '0) && !r_ovf)
        else $error("line state not cleared while replaying");

    a_newline_starts_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == tla_pkg::S_READ) && $past(r_state == tla_pkg::S_IDLE)
            |-> r_idx == '0)
        else $error("replay did not start at entry zero");

endmodule

>>> tb/sv/telnet_line_assembler_test.sv
// self-checking testbench for telnet_line_assembler: received bytes in, assembled lines out
// depends on tla_pkg and telnet_line_assembler; predicts every line result and compares in order
`timescale 1ns / 1ps

module telnet_line_assembler_test;

    localparam int CAP_USED    = (tla_pkg::LINE_CAP < 1) ? 1 :
        ((tla_pkg::LINE_CAP > tla_pkg::STORE_DEPTH) ? tla_pkg::STORE_DEPTH : tla_pkg::LINE_CAP);
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 420;

    typedef struct {
        logic [7:0] rx_byte;
        logic       chunk_start;
        int         gap_after;
        bit         wait_drain;
    } t_rx_byte;

    typedef struct {
        logic [6:0] ch;
        logic       present;
        logic       last;
        logic       trunc;
    } t_line_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;     // [7:0] in_byte
    logic       s_axis_tuser = 1'b0;     // [0] chunk_start
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [6:0] line_char, [7] zero fill
    logic [1:0] m_axis_tuser;            // [0] char_present, [1] truncated
    logic       m_axis_tlast;            // last_of_line

    t_rx_byte     pending_bytes[$];
    t_line_result line_results_due[$];
    int           error_count = 0;
    int           cycle_count = 0;
    int           tx_calm = 0;
    int           rx_calm = 0;
    int           rx_stall = 0;
    int           gap_left = 0;
    int           gap_after = 0;

    // predictor state
    logic [6:0]   held_chars[tla_pkg::STORE_DEPTH];
    int           held_len = 0;
    bit           skip_chunk = 0;
    bit           just_ended = 0;
    bit           lost_chars = 0;

    telnet_line_assembler u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    function automatic void replay_line();
        t_line_result r;
        if (held_len == 0) begin
            r.ch = 7'd0;
            r.present = 1'b0;
            r.last = 1'b1;
            r.trunc = lost_chars;
            line_results_due.push_back(r);
        end else begin
            for (int k = 0; k < held_len; k++) begin
                r.ch = held_chars[k];
                r.present = 1'b1;
                r.last = (k == held_len - 1);
                r.trunc = lost_chars;
                line_results_due.push_back(r);
            end
        end
        held_len = 0;
        lost_chars = 0;
    endfunction

    function automatic void assemble_byte(input logic [7:0] b, input logic first);
        bit printable;
        printable = (b >= tla_pkg::BYTE_SPACE) && (b <= tla_pkg::BYTE_TILDE);
        if (first) begin
            skip_chunk = 0;
            just_ended = 0;
            if (!printable && b != tla_pkg::BYTE_CR && b != tla_pkg::BYTE_LF) begin
                skip_chunk = 1;
                return;
            end
        end else if (skip_chunk) begin
            return;
        end else if (just_ended) begin
            just_ended = 0;
            // CR LF and the like collapse into one line
            if (b < tla_pkg::BYTE_SPACE || b[7])
                return;
        end
        if (b == tla_pkg::BYTE_DEL || b == tla_pkg::BYTE_IAC_E)
            return;
        if (b == tla_pkg::BYTE_BS) begin
            if (held_len > 0)
                held_len--;
            return;
        end
        if (b == tla_pkg::BYTE_CR || b == tla_pkg::BYTE_LF) begin
            just_ended = 1;
            replay_line();
            return;
        end
        if (printable) begin
            if (held_len < CAP_USED) begin
                held_chars[held_len] = b[6:0];
                held_len++;
            end else begin
                lost_chars = 1;
            end
        end
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic first);
        t_rx_byte it;
        it.rx_byte = b;
        it.chunk_start = first;
        it.wait_drain = 0;
        if (tx_calm > 0) begin
            tx_calm--;
            it.gap_after = 0;
        end else begin
            if ($urandom_range(0, 24) == 0)
                tx_calm = 40;
            it.gap_after = $urandom_range(0, 6);
        end
        pending_bytes.push_back(it);
    endfunction

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0: b = 8'd0;
            1: b = tla_pkg::BYTE_BS;
            2: b = tla_pkg::BYTE_DEL;
            3: b = tla_pkg::BYTE_IAC_E;
            4: b = 8'($urandom_range(128, 255));
            default: begin
                b = 8'($urandom_range(0, 31));
                if (b == tla_pkg::BYTE_CR || b == tla_pkg::BYTE_LF)
                    b = 8'd0;
            end
        endcase
        return b;
    endfunction

    function automatic void add_random_part();
        int len;
        bit open_chunk;
        bit first_line;
        open_chunk = 0;
        first_line = 1;
        while (pending_bytes.size() < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    // chunk opened by a bad byte, all of it dropped
                    add_byte(junk_byte(), 1'b1);
                    repeat ($urandom_range(0, 5))
                        add_byte(8'($urandom_range(0, 255)), 1'b0);
                    open_chunk = 0;
                end
                1: begin
                    repeat ($urandom_range(1, 8))
                        add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                    open_chunk = 0;
                end
                default: begin
                    if (first_line)
                        len = $urandom_range(65, 70);
                    else if ($urandom_range(0, 7) == 0)
                        len = $urandom_range(60, 72);
                    else
                        len = $urandom_range(0, 20);
                    first_line = 0;
                    for (int k = 0; k < len; k++) begin
                        if (k > 0 && $urandom_range(0, 9) == 0)
                            add_byte(junk_byte(), 1'b0);
                        add_byte(8'($urandom_range(32, 126)), k == 0 && !open_chunk);
                    end
                    add_byte($urandom_range(0, 1) ? tla_pkg::BYTE_CR : tla_pkg::BYTE_LF,
                             len == 0 && !open_chunk);
                    case ($urandom_range(0, 5))
                        0, 1: add_byte($urandom_range(0, 1) ? tla_pkg::BYTE_LF : tla_pkg::BYTE_CR,
                                       1'b0);
                        2: add_byte(8'($urandom_range(0, 255)), 1'b0);
                        default: ;
                    endcase
                    open_chunk = $urandom_range(0, 2) == 0;
                end
            endcase
        end
        // the sender holds off once mid-run until the output side has drained
        pending_bytes[RANDOM_ITEMS / 2].wait_drain = 1;
    endfunction

    initial begin
        // plain line, then LF swallowed right after CR
        add_byte("h", 1'b1);
        add_byte("i", 1'b0);
        add_byte(tla_pkg::BYTE_CR, 1'b0);
        add_byte(tla_pkg::BYTE_LF, 1'b0);
        // empty line opened by LF
        add_byte(tla_pkg::BYTE_LF, 1'b1);
        // backspace on empty, ignored and control bytes, field extremes
        add_byte("a", 1'b1);
        add_byte(tla_pkg::BYTE_BS, 1'b0);
        add_byte(tla_pkg::BYTE_BS, 1'b0);
        add_byte(tla_pkg::BYTE_DEL, 1'b0);
        add_byte(tla_pkg::BYTE_IAC_E, 1'b0);
        add_byte(8'd0, 1'b0);
        add_byte(8'd255, 1'b0);
        add_byte(tla_pkg::BYTE_TILDE, 1'b0);
        add_byte(tla_pkg::BYTE_SPACE, 1'b0);
        add_byte(tla_pkg::BYTE_CR, 1'b0);
        // chunk opened by backspace is dropped whole
        add_byte(tla_pkg::BYTE_BS, 1'b1);
        add_byte("x", 1'b0);
        add_byte(tla_pkg::BYTE_CR, 1'b0);
        // printable right after CR is kept; the look-ahead stops at a chunk edge
        add_byte(tla_pkg::BYTE_CR, 1'b1);
        add_byte("q", 1'b0);
        add_byte(tla_pkg::BYTE_LF, 1'b0);
        add_byte(tla_pkg::BYTE_LF, 1'b1);
        add_byte(8'd200, 1'b1);
        add_byte("z", 1'b1);
        add_byte(tla_pkg::BYTE_CR, 1'b0);
        add_random_part();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_bytes.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (line_results_due.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    // sender: one byte per transfer, random gap after each
    always @(posedge i_clk) begin
        logic     fire;
        t_rx_byte item;
        fire = s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'd0;
            s_axis_tuser  <= 1'b0;
            gap_left = 0;
        end else begin
            if (fire) begin
                assemble_byte(s_axis_tdata, s_axis_tuser);
                gap_left = gap_after;
            end
            if (!s_axis_tvalid || fire) begin
                if (gap_left > 0) begin
                    s_axis_tvalid <= 1'b0;
                    gap_left--;
                end else if (pending_bytes.size() > 0 &&
                             !(pending_bytes[0].wait_drain && line_results_due.size() > 0)) begin
                    item = pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= item.rx_byte;
                    s_axis_tuser  <= item.chunk_start;
                    gap_after = item.gap_after;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each transfer against the oldest predicted result
    always @(posedge i_clk) begin
        t_line_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_stall = 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (line_results_due.size() == 0) begin
                report_mismatch("result with nothing pending, tdata", m_axis_tdata, 0);
            end else begin
                want = line_results_due.pop_front();
                if (m_axis_tdata !== {1'b0, want.ch})
                    report_mismatch("line_char", m_axis_tdata, want.ch);
                if (m_axis_tuser[0] !== want.present)
                    report_mismatch("char_present", m_axis_tuser[0], want.present);
                if (m_axis_tuser[1] !== want.trunc)
                    report_mismatch("truncated", m_axis_tuser[1], want.trunc);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_of_line", m_axis_tlast, want.last);
            end
            if (rx_calm > 0) begin
                rx_calm--;
                rx_stall = 0;
            end else begin
                if ($urandom_range(0, 24) == 0)
                    rx_calm = 40;
                rx_stall = $urandom_range(0, 6);
            end
            m_axis_tready <= (rx_stall == 0);
        end else if (!m_axis_tready) begin
            if (rx_stall <= 1) begin
                m_axis_tready <= 1'b1;
                rx_stall = 0;
            end else begin
                rx_stall--;
            end
        end
    end

endmodule
